FILE: src/osl_pkg.sv
`default_nettype none
package osl_pkg;

    localparam int POOL_NODES = 256;
    localparam int MAX_HEIGHT = 16;
    localparam int KEY_BITS   = 32;

    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

    typedef enum logic [1:0] {
        CMD_SEARCH = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_BAD    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_NFOUND = 3'd1,
        ST_DUP    = 3'd2,
        ST_FULL   = 3'd3,
        ST_BADCMD = 3'd4
    } t_status;

    // datapath operation for the current cycle
    typedef enum logic [3:0] {
        DP_NOP,
        DP_START,   // capture key, point at head, top level
        DP_LRD,     // read link of current node at walk level
        DP_KRD,     // latch next node, read its key
        DP_CMP,     // step right or drop one level
        DP_DRAW,    // draw height, pop free node
        DP_NEW,     // store key in new node
        DP_IRD,     // read predecessor link
        DP_IWN,     // new node link <= predecessor link
        DP_IWP,     // predecessor link <= new node
        DP_DRD,     // read predecessor link
        DP_DCHK,    // compare with victim, read victim link
        DP_DWR,     // predecessor link <= victim link
        DP_PUSH,    // return victim to free stack
        DP_SHRINK   // drop an empty top level
    } t_dp_op;

    typedef struct packed {
        logic       level_zero;
        logic       lvl_zero;
        logic       adv;
        logic       found;
        logic       fc_zero;
        logic       i_last;
        logic       i_end;
        logic       link_is_x;
        logic       shrink_more;
        logic [8:0] elem_count;
    } t_dp_stat;

endpackage
`default_nettype wire

FILE: src/osl_if.sv
`default_nettype none
interface osl_req_if #(parameter int KEY_BITS = osl_pkg::KEY_BITS);
    logic                       valid;
    logic                       ready;
    logic [1:0]                 cmd;
    logic signed [KEY_BITS-1:0] key;
    modport source (output valid, output cmd, output key, input ready);
    modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface osl_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [8:0] element_count;
    modport source (output valid, output status, output element_count, input ready);
    modport sink   (input valid, input status, input element_count, output ready);
endinterface
`default_nettype wire

FILE: src/osl_dp.sv
`default_nettype none
module osl_dp #(
    parameter int POOL_NODES = osl_pkg::POOL_NODES,
    parameter int MAX_HEIGHT = osl_pkg::MAX_HEIGHT,
    parameter int KEY_BITS   = osl_pkg::KEY_BITS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire osl_pkg::t_dp_op            i_op,
    input  wire logic signed [KEY_BITS-1:0] i_key,
    input  wire logic                       i_cfg_we,
    input  wire logic [31:0]                i_cfg_wdata,
    output osl_pkg::t_dp_stat               o_stat
);

    localparam int IW   = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int LW   = $clog2(POOL_NODES + 2);
    localparam int CW   = $clog2(POOL_NODES + 1);
    localparam int LVW  = $clog2(MAX_HEIGHT);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int AW   = IW + LVW;
    localparam int HCAP = (MAX_HEIGHT < 32) ? MAX_HEIGHT : 32;
    localparam logic [LW-1:0] NIL  = LW'(POOL_NODES);
    localparam logic [LW-1:0] HEAD = LW'(POOL_NODES + 1);
    localparam logic [CW-1:0] POOL = CW'(POOL_NODES);

    // storage
    logic signed [KEY_BITS-1:0] key_mem   [POOL_NODES];
    logic [LW-1:0]              link_mem  [1 << AW];
    logic [IW-1:0]              stack_mem [POOL_NODES];
    logic [LW-1:0]              r_heads   [MAX_HEIGHT];
    logic [LW-1:0]              r_path    [MAX_HEIGHT];

    logic signed [KEY_BITS-1:0] r_key, r_key_q;
    logic [LW-1:0]  r_x, r_nx, r_link_q, r_head_q;
    logic           r_lrd_head;
    logic [LVW-1:0] r_lvl;
    logic [HW-1:0]  r_level, r_h;
    logic [IW-1:0]  r_n, r_stack_q, r_pop_alt;
    logic           r_pop_fresh;
    logic [CW-1:0]  r_fc, r_low;
    logic [31:0]    r_lfsr;

    logic [LW-1:0]  linkout, rd_node, wr_node, wr_data;
    logic           rd_en, wr_en;
    logic [31:0]    lfsr_nx;
    logic [HW-1:0]  h_draw, lvl_m1;
    logic [CW-1:0]  fc_m1;
    logic [IW-1:0]  new_n;
    logic           nx_valid, shrink_c;
    logic [31:0]    cnt_w;

    assign linkout  = r_lrd_head ? r_head_q : r_link_q;
    assign lfsr_nx  = r_lfsr[0] ? ((r_lfsr >> 1) ^ osl_pkg::LFSR_TAPS) : (r_lfsr >> 1);
    assign lvl_m1   = r_level - HW'(1);
    assign fc_m1    = r_fc - CW'(1);
    assign new_n    = r_pop_fresh ? r_pop_alt : r_stack_q;
    assign nx_valid = (r_nx < NIL);
    assign shrink_c = (r_level > HW'(1)) && (r_heads[lvl_m1[LVW-1:0]] == NIL);
    assign cnt_w    = 32'(POOL_NODES) - 32'(r_fc);

    // height: one plus trailing zeros of the new LFSR state, capped
    always_comb begin
        h_draw = HW'(1);
        for (int j = 1; j < HCAP; j++) begin
            if ((lfsr_nx & ((32'd1 << j) - 32'd1)) == 32'd0) begin
                h_draw = HW'(j + 1);
            end
        end
    end

    // link port address/data selection
    always_comb begin
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        rd_node = r_x;
        wr_node = r_path[r_lvl];
        wr_data = linkout;
        case (i_op)
            osl_pkg::DP_LRD: begin
                rd_en = 1'b1;
            end
            osl_pkg::DP_IRD, osl_pkg::DP_DRD: begin
                rd_en   = 1'b1;
                rd_node = r_path[r_lvl];
            end
            osl_pkg::DP_DCHK: begin
                rd_en   = 1'b1;
                rd_node = r_nx;
            end
            osl_pkg::DP_IWN: begin
                wr_en   = 1'b1;
                wr_node = LW'(r_n);
            end
            osl_pkg::DP_IWP: begin
                wr_en   = 1'b1;
                wr_data = LW'(r_n);
            end
            osl_pkg::DP_DWR: begin
                wr_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_lrd_head <= (rd_node == HEAD);
            r_head_q   <= r_heads[r_lvl];
            r_link_q   <= link_mem[{rd_node[IW-1:0], r_lvl}];
        end
        if (wr_en && wr_node != HEAD) begin
            link_mem[{wr_node[IW-1:0], r_lvl}] <= wr_data;
        end
        if (i_op == osl_pkg::DP_KRD) begin
            r_key_q <= key_mem[linkout[IW-1:0]];
        end
        if (i_op == osl_pkg::DP_NEW) begin
            key_mem[new_n] <= r_key;
        end
        if (i_op == osl_pkg::DP_DRAW) begin
            r_stack_q <= stack_mem[fc_m1[IW-1:0]];
        end
        if (i_op == osl_pkg::DP_PUSH && r_fc < POOL) begin
            stack_mem[r_fc[IW-1:0]] <= r_nx[IW-1:0];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            osl_pkg::DP_START: begin
                r_key <= i_key;
                r_x   <= HEAD;
            end
            osl_pkg::DP_KRD: begin
                r_nx <= linkout;
            end
            osl_pkg::DP_CMP: begin
                if (o_stat.adv) begin
                    r_x <= r_nx;
                end else begin
                    r_path[r_lvl] <= r_x;
                end
            end
            osl_pkg::DP_DRAW: begin
                r_pop_fresh <= (r_fc == r_low);
                r_pop_alt   <= IW'(POOL - r_fc);
                if (h_draw > r_level) begin
                    r_h                       <= r_level + HW'(1);
                    r_path[r_level[LVW-1:0]] <= HEAD;
                end else begin
                    r_h <= h_draw;
                end
            end
            osl_pkg::DP_NEW: begin
                r_n <= new_n;
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_fc    <= POOL;
            r_low   <= POOL;
            r_lfsr  <= 32'd1;
            r_lvl   <= '0;
            for (int j = 0; j < MAX_HEIGHT; j++) begin
                r_heads[j] <= NIL;
            end
        end else begin
            if (i_cfg_we) begin
                r_lfsr <= (i_cfg_wdata == 32'd0) ? 32'd1 : i_cfg_wdata;
            end
            if (wr_en && wr_node == HEAD) begin
                r_heads[r_lvl] <= wr_data;
            end
            case (i_op)
                osl_pkg::DP_START: begin
                    r_lvl <= lvl_m1[LVW-1:0];
                end
                osl_pkg::DP_CMP: begin
                    if (!o_stat.adv && r_lvl != '0) begin
                        r_lvl <= r_lvl - LVW'(1);
                    end
                end
                osl_pkg::DP_DRAW: begin
                    r_lfsr <= lfsr_nx;
                    r_lvl  <= '0;
                    r_fc   <= fc_m1;
                    if (r_fc == r_low) begin
                        r_low <= fc_m1;
                    end
                    if (h_draw > r_level) begin
                        r_level <= r_level + HW'(1);
                    end
                end
                osl_pkg::DP_IWP, osl_pkg::DP_DWR: begin
                    r_lvl <= r_lvl + LVW'(1);
                end
                osl_pkg::DP_PUSH: begin
                    if (r_fc < POOL) begin
                        r_fc <= r_fc + CW'(1);
                    end
                end
                osl_pkg::DP_SHRINK: begin
                    if (shrink_c) begin
                        r_level <= lvl_m1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_stat.level_zero  = (r_level == '0);
        o_stat.lvl_zero    = (r_lvl == '0);
        o_stat.adv         = nx_valid && (r_key_q < r_key);
        o_stat.found       = nx_valid && (r_key_q == r_key);
        o_stat.fc_zero     = (r_fc == '0);
        o_stat.i_last      = (HW'(r_lvl) + HW'(1) == r_h);
        o_stat.i_end       = (HW'(r_lvl) + HW'(1) == r_level);
        o_stat.link_is_x   = (linkout == r_nx);
        o_stat.shrink_more = shrink_c;
        o_stat.elem_count  = cnt_w[8:0];
    end

    a_fc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc <= POOL) else $error("free count above pool size");
    a_low_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_fc) else $error("fresh mark above free count");
    a_empty_lvl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_level == '0) |-> (r_fc == POOL)) else $error("level zero with keys held");

endmodule
`default_nettype wire

FILE: src/osl_ctrl.sv
`default_nettype none
module osl_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [1:0]        i_in_cmd,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [2:0]             o_status,
    output logic [8:0]             o_count,
    output osl_pkg::t_dp_op        o_op,
    input  wire osl_pkg::t_dp_stat i_stat
);

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_LRD    = 15'b000000000000010,
        S_KRD    = 15'b000000000000100,
        S_CMP    = 15'b000000000001000,
        S_DRAW   = 15'b000000000010000,
        S_NEW    = 15'b000000000100000,
        S_IRD    = 15'b000000001000000,
        S_IWN    = 15'b000000010000000,
        S_IWP    = 15'b000000100000000,
        S_DRD    = 15'b000001000000000,
        S_DCHK   = 15'b000010000000000,
        S_DWR    = 15'b000100000000000,
        S_PUSH   = 15'b001000000000000,
        S_SHRINK = 15'b010000000000000,
        S_DONE   = 15'b100000000000000
    } t_state;

    t_state            r_state, n_state;
    osl_pkg::t_cmd     r_cmd, n_cmd, cmd_sel;
    osl_pkg::t_status  r_res, n_res;
    logic              r_out_valid;
    logic [2:0]        r_status;
    logic [8:0]        r_count;
    logic              post, found_now, load_out;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_res     = r_res;
        o_op      = osl_pkg::DP_NOP;
        post      = 1'b0;
        found_now = 1'b0;
        load_out  = 1'b0;
        cmd_sel   = (r_state == S_IDLE) ? osl_pkg::t_cmd'(i_in_cmd) : r_cmd;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op  = osl_pkg::DP_START;
                    n_cmd = osl_pkg::t_cmd'(i_in_cmd);
                    if (osl_pkg::t_cmd'(i_in_cmd) == osl_pkg::CMD_BAD) begin
                        n_res   = osl_pkg::ST_BADCMD;
                        n_state = S_DONE;
                    end else if (i_stat.level_zero) begin
                        post = 1'b1;
                    end else begin
                        n_state = S_LRD;
                    end
                end
            end
            S_LRD: begin
                o_op    = osl_pkg::DP_LRD;
                n_state = S_KRD;
            end
            S_KRD: begin
                o_op    = osl_pkg::DP_KRD;
                n_state = S_CMP;
            end
            S_CMP: begin
                o_op = osl_pkg::DP_CMP;
                if (i_stat.adv || !i_stat.lvl_zero) begin
                    n_state = S_LRD;
                end else begin
                    post      = 1'b1;
                    found_now = i_stat.found;
                end
            end
            S_DRAW: begin
                o_op    = osl_pkg::DP_DRAW;
                n_state = S_NEW;
            end
            S_NEW: begin
                o_op    = osl_pkg::DP_NEW;
                n_state = S_IRD;
            end
            S_IRD: begin
                o_op    = osl_pkg::DP_IRD;
                n_state = S_IWN;
            end
            S_IWN: begin
                o_op    = osl_pkg::DP_IWN;
                n_state = S_IWP;
            end
            S_IWP: begin
                o_op = osl_pkg::DP_IWP;
                if (i_stat.i_last) begin
                    n_res   = osl_pkg::ST_OK;
                    n_state = S_DONE;
                end else begin
                    n_state = S_IRD;
                end
            end
            S_DRD: begin
                o_op    = osl_pkg::DP_DRD;
                n_state = S_DCHK;
            end
            S_DCHK: begin
                o_op    = osl_pkg::DP_DCHK;
                n_state = i_stat.link_is_x ? S_DWR : S_PUSH;
            end
            S_DWR: begin
                o_op    = osl_pkg::DP_DWR;
                n_state = i_stat.i_end ? S_PUSH : S_DRD;
            end
            S_PUSH: begin
                o_op    = osl_pkg::DP_PUSH;
                n_state = S_SHRINK;
            end
            S_SHRINK: begin
                o_op = osl_pkg::DP_SHRINK;
                if (!i_stat.shrink_more) begin
                    n_res   = osl_pkg::ST_OK;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // search finished: dispatch on the command
        if (post) begin
            unique case (cmd_sel)
                osl_pkg::CMD_SEARCH: begin
                    n_res   = found_now ? osl_pkg::ST_OK : osl_pkg::ST_NFOUND;
                    n_state = S_DONE;
                end
                osl_pkg::CMD_INSERT: begin
                    if (found_now) begin
                        n_res   = osl_pkg::ST_DUP;
                        n_state = S_DONE;
                    end else if (i_stat.fc_zero) begin
                        n_res   = osl_pkg::ST_FULL;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_DRAW;
                    end
                end
                osl_pkg::CMD_DELETE: begin
                    if (found_now) begin
                        n_state = S_DRD;
                    end else begin
                        n_res   = osl_pkg::ST_NFOUND;
                        n_state = S_DONE;
                    end
                end
                default: begin
                    n_res   = osl_pkg::ST_BADCMD;
                    n_state = S_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_res <= n_res;
        if (load_out) begin
            r_status <= r_res;
            r_count  <= i_stat.elem_count;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_count     = r_count;

    a_load_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(r_state == S_DONE))
        else $error("result beat raised outside completion");

endmodule
`default_nettype wire

FILE: src/ordered_set_skip_list.sv
`default_nettype none
// Ordered set of signed keys held as a skip list in a fixed node pool.
// Request channel i_req (cmd, key): cmd 0 search, 1 insert, 2 delete,
// 3 is answered with status 4 and changes nothing. Each request gives
// exactly one response beat on o_rsp: status and the key count after it.
// Config: i_cfg_we/i_cfg_wdata load the height LFSR seed (zero loads 1);
// write only while the block is idle.
// Sequencing: the search walks links one step per node visited or
// level dropped (link read, key read, compare), set by the single-port
// link and key memories. Insert then draws the height and stores the
// key, then per level reads the predecessor link and writes the new and
// predecessor links. Delete per level reads, checks and rewrites the
// predecessor link, stopping below the top level when it no longer
// points at the victim; then frees the node, drops empty levels one
// check at a time, and loads the response register. One request at a time.
// Reset (synchronous, active low): empty set, level 0, all nodes free,
// LFSR = 1. Node memories are not cleared; no clearing pass is needed.
// Back-pressure: the response sits in an output register; a new request
// is taken while it waits, and the block holds a finished result until
// the register frees.
module ordered_set_skip_list #(
    parameter int POOL_NODES = osl_pkg::POOL_NODES,
    parameter int MAX_HEIGHT = osl_pkg::MAX_HEIGHT,
    parameter int KEY_BITS   = osl_pkg::KEY_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    osl_req_if.sink          i_req,
    osl_rsp_if.source        o_rsp,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata
);

    osl_pkg::t_dp_op   dp_op;
    osl_pkg::t_dp_stat dp_stat;
    logic signed [KEY_BITS-1:0] req_key;

    assign req_key = i_req.key;

    osl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_in_cmd    (i_req.cmd),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_status    (o_rsp.status),
        .o_count     (o_rsp.element_count),
        .o_op        (dp_op),
        .i_stat      (dp_stat)
    );

    // memories, walk pointers, free stack and LFSR
    osl_dp #(
        .POOL_NODES (POOL_NODES),
        .MAX_HEIGHT (MAX_HEIGHT),
        .KEY_BITS   (KEY_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (dp_op),
        .i_key       (req_key),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_stat      (dp_stat)
    );

endmodule
`default_nettype wire

FILE: tb/tb_osl_if.sv
`timescale 1ns / 1ps
// Testbench-side copies are not needed: the RTL interfaces are reused.
// This file holds the channel-level idle helper shared by the testbench.
package tb_osl_pkg;
    // burst length of an idle stretch on either channel
    function automatic int unsigned idle_burst();
        return $urandom_range(1, 8);
    endfunction
endpackage

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import osl_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;

    osl_req_if req_if ();
    osl_rsp_if rsp_if ();

    ordered_set_skip_list u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if.sink),
        .o_rsp      (rsp_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Set model: skip list mirrored with the same pool, links, LFSR.
    // Keys are kept as offset-binary so unsigned compare orders them.
    // ---------------------------------------------------------------
    localparam int NIL  = POOL_NODES;
    localparam int HEAD = POOL_NODES + 1;

    typedef struct packed {
        t_status    status;
        logic [8:0] count;
    } t_answer;

    logic [31:0] set_key [POOL_NODES];
    int          set_link[POOL_NODES][MAX_HEIGHT];
    int          head_link[MAX_HEIGHT];
    int          set_level;
    int          free_list[POOL_NODES];
    int          free_cnt;
    logic [31:0] lfsr;

    t_answer answer_q[$];
    int      mismatches = 0;
    int      cycles = 0;
    bit      idle_on = 1'b1;   // random gaps on both channels

    function automatic int link_of(int node, int lvl);
        if (node == HEAD) return head_link[lvl];
        return set_link[node][lvl];
    endfunction

    function automatic void link_put(int node, int lvl, int to);
        if (node == HEAD) head_link[lvl] = to;
        else set_link[node][lvl] = to;
    endfunction

    function automatic void set_clear();
        for (int i = 0; i < MAX_HEIGHT; i++) head_link[i] = NIL;
        for (int i = 0; i < POOL_NODES; i++) free_list[i] = POOL_NODES - 1 - i;
        free_cnt = POOL_NODES;
        set_level = 0;
        lfsr = 32'd1;
    endfunction

    function automatic int next_height();
        int h;
        logic [31:0] s;
        h = 1;
        s = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
        lfsr = s;
        while (s[0] == 1'b0 && h < MAX_HEIGHT) begin
            h++;
            s = s >> 1;
        end
        return h;
    endfunction

    function automatic t_answer set_apply(t_cmd cmd, logic signed [31:0] key);
        int path[MAX_HEIGHT];
        int x, nx, h, n;
        logic [31:0] k;
        bit hit;
        t_answer a;
        k = key ^ 32'h8000_0000;
        for (int i = 0; i < MAX_HEIGHT; i++) path[i] = HEAD;
        a.status = ST_OK;
        if (cmd != CMD_BAD) begin
            // walk down from the top level
            x = HEAD;
            for (int i = set_level; i > 0; i--) begin
                nx = link_of(x, i - 1);
                while (nx < NIL && set_key[nx] < k) begin
                    x = nx;
                    nx = link_of(x, i - 1);
                end
                path[i - 1] = x;
            end
            x = link_of(x, 0);
            hit = (x < NIL) && (set_key[x] == k);
        end
        case (cmd)
            CMD_SEARCH: a.status = hit ? ST_OK : ST_NFOUND;
            CMD_INSERT: begin
                if (hit) a.status = ST_DUP;
                else if (free_cnt == 0) a.status = ST_FULL;
                else begin
                    h = next_height();
                    if (h > set_level) begin
                        set_level++;
                        h = set_level;
                        path[h - 1] = HEAD;
                    end
                    free_cnt--;
                    n = free_list[free_cnt];
                    set_key[n] = k;
                    for (int i = 0; i < h; i++) begin
                        set_link[n][i] = link_of(path[i], i);
                        link_put(path[i], i, n);
                    end
                end
            end
            CMD_DELETE: begin
                if (!hit) a.status = ST_NFOUND;
                else begin
                    for (int i = 0; i < set_level; i++) begin
                        if (link_of(path[i], i) != x) break;
                        link_put(path[i], i, set_link[x][i]);
                    end
                    free_list[free_cnt] = x;
                    free_cnt++;
                    // drop empty top levels, keeping at least one
                    while (set_level > 1 && head_link[set_level - 1] == NIL)
                        set_level--;
                end
            end
            default: a.status = ST_BADCMD;
        endcase
        a.count = 9'(POOL_NODES - free_cnt);
        return a;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        mismatches++;
    endtask

    // ---- request side: one beat per call, inputs move on the falling edge
    // valid stays up between back-to-back calls; gaps and drain drop it
    task automatic send_req(t_cmd cmd, logic signed [31:0] key);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat (tb_osl_pkg::idle_burst()) @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.cmd   <= cmd;
        req_if.key   <= key;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        answer_q.push_back(set_apply(cmd, key));
        @(negedge i_clk);
    endtask

    // ---- response side: random stall bursts on ready
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat (tb_osl_pkg::idle_burst() - 1) @(negedge i_clk);
            end else
                rsp_if.ready <= 1'b1;
        end
    end

    // ---- result check at each accepted response beat
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (answer_q.size() == 0) begin
                report("unexpected beat", rsp_if.status, -1);
            end else begin
                want = answer_q.pop_front();
                if (rsp_if.status !== want.status)
                    report("status", rsp_if.status, want.status);
                if (rsp_if.element_count !== want.count)
                    report("element_count", rsp_if.element_count, want.count);
            end
        end
    end

    // ---- watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout");
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic drain();
        req_if.valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    // seed write only between phases, block idle
    task automatic load_seed(logic [31:0] seed);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= seed;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        lfsr = (seed == 0) ? 32'd1 : seed;
    endtask

    function automatic t_cmd pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return CMD_INSERT;
        if (r < 70) return CMD_DELETE;
        if (r < 97) return CMD_SEARCH;
        return CMD_BAD;
    endfunction

    // keys from a narrow window so hits, duplicates and deletes are common
    function automatic logic signed [31:0] pick_key(int span);
        if ($urandom_range(0, 15) == 0) return $urandom();
        return $signed($urandom_range(0, span)) - span / 2;
    endfunction

    // directed: key extremes, every command, bad command, level shrink
    task automatic test_directed();
        send_req(CMD_SEARCH, 32'sh8000_0000);
        send_req(CMD_DELETE, 0);
        send_req(CMD_INSERT, 32'sh8000_0000);
        send_req(CMD_INSERT, 32'sh7fff_ffff);
        send_req(CMD_INSERT, -1);
        send_req(CMD_INSERT, 0);
        send_req(CMD_INSERT, 32'sh7fff_ffff);      // duplicate
        send_req(CMD_SEARCH, 32'sh7fff_ffff);
        send_req(CMD_SEARCH, 32'sh8000_0000);
        send_req(CMD_SEARCH, 1);
        send_req(CMD_BAD, 32'sh5555_aaaa);
        send_req(CMD_BAD, 32'shaaaa_5555);
        send_req(CMD_DELETE, -1);
        send_req(CMD_DELETE, 32'sh7fff_ffff);
        send_req(CMD_DELETE, 32'sh8000_0000);
        send_req(CMD_DELETE, 0);                  // list empty again, shrink
        send_req(CMD_DELETE, 0);
        send_req(CMD_SEARCH, 0);
    endtask

    task automatic test_random(int n, int span);
        for (int i = 0; i < n; i++) send_req(pick_cmd(), pick_key(span));
    endtask

    // fill the pool to the last node, then full and duplicate-when-full
    task automatic test_full_pool();
        int k;
        k = 1000;
        while (free_cnt > 0) begin
            send_req(CMD_INSERT, k);
            k += 3;
        end
        send_req(CMD_INSERT, 7);                  // full
        send_req(CMD_INSERT, 1000);               // duplicate beats full
        send_req(CMD_SEARCH, k - 3);
        for (int i = 0; i < 60; i++)
            send_req(pick_cmd(), 1000 + 3 * $urandom_range(0, 300));
        while (free_cnt < POOL_NODES) begin       // tear down, shrinking levels
            send_req(CMD_DELETE, set_key[link_of(HEAD, 0)] ^ 32'h8000_0000);
        end
    endtask

    initial begin
        req_if.valid = 1'b0;
        req_if.cmd   = CMD_SEARCH;
        req_if.key   = '0;
        set_clear();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(300, 64);
        load_seed(32'hffff_ffff);
        test_random(250, 400);
        load_seed(32'd0);                         // zero seed loads 1
        test_full_pool();
        load_seed(32'h8000_0000);
        test_random(250, 40);
        load_seed($urandom() | 32'd1);
        idle_on = 1'b0;                           // closing stretch at full rate
        test_random(100, 128);

        drain();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
